/* sv/tdm_pkg.sv */
// Shared types and constants for the periodic task deadline monitor.
package tdm_pkg;

   localparam int NUM_TASKS = 8;
   localparam int TASK_AW   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int ID_W      = 3;
   localparam int OP_W      = 2;
   localparam int TIME_W    = 32;
   localparam int PER_W     = 16;
   localparam int SUM_W     = 48;
   localparam int CNT_W     = 32;
   localparam int DIV_CW    = $clog2(SUM_W + 1);

   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_END   = 2'd2;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   typedef struct packed {
      logic [PER_W-1:0]  period;
      logic [TIME_W-1:0] first_act;
      logic [TIME_W-1:0] last_act;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] max_exec;
      logic [SUM_W-1:0]  sum_exec;
      logic [CNT_W-1:0]  job_count;
      logic [CNT_W-1:0]  miss;
      logic [TIME_W-1:0] avg_exec;
   } entry_type;

   typedef struct packed {
      logic              go;
      logic              narrow;
      logic [SUM_W-1:0]  num;
      logic [TIME_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SUM_W-1:0]  quot;
      logic [TIME_W-1:0] rem;
   } div_rsp_type;

endpackage

/* sv/tdm_ram.sv */
// Task table: one synchronous memory with a registered read port.
module tdm_ram
   import tdm_pkg::*;
(
   input  logic               clock,
   input  logic [TASK_AW-1:0] rd_addr,
   output entry_type          rd_data,
   input  logic               wr_en,
   input  logic [TASK_AW-1:0] wr_addr,
   input  entry_type          wr_data
);

   entry_type mem [NUM_TASKS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tdm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both divisions.
module tdm_div
   import tdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] den_ff;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[SUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.go) begin
         // narrow dividends sit in the top bits so fewer steps are needed
         quot_in = req.narrow ? {req.num[TIME_W-1:0], {(SUM_W-TIME_W){1'b0}}}
                              : req.num;
         rem_in  = '0;
         cnt_in  = req.narrow ? DIV_CW'(TIME_W) : DIV_CW'(SUM_W);
      end else if (cnt_ff != '0) begin
         if (!diff[TIME_W]) begin
            rem_in  = diff[TIME_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[TIME_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (req.go) begin
         den_ff <= req.den;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

/* sv/periodic_task_deadline_monitor_unit.sv */
// Periodic task deadline monitor: sequencer around the task table and divider.
// One request is taken at a time; busy is high from the cycle after start is
// accepted until the result strobe. A start with a nonzero period and an end
// use the shared divider, which produces one quotient bit per cycle (32 steps
// for the activation remainder, 48 for the average); an init, an unused op
// or an invalid task id does not. rsp_valid is high for a single cycle and
// the receiver cannot hold it off; a new request may be started in the same
// cycle that the result is shown. Table entries hold no meaningful data until
// the task has been initialized.
module periodic_task_deadline_monitor_unit
   import tdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [TIME_W-1:0] req_now_ms,
   input  logic [PER_W-1:0]  req_period_ms,
   output logic              rsp_valid,
   output logic [ID_W-1:0]   rsp_task_out,
   output logic [TIME_W-1:0] rsp_activation_ms,
   output logic [TIME_W-1:0] rsp_deadline_ms,
   output logic [TIME_W-1:0] rsp_exec_time_ms,
   output logic [TIME_W-1:0] rsp_max_exec_ms,
   output logic [TIME_W-1:0] rsp_avg_exec_ms,
   output logic [CNT_W-1:0]  rsp_miss_count,
   output logic              rsp_missed_now
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_UPDATE = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_WRITE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   id_ff;
   logic              id_ok_ff;
   logic [TIME_W-1:0] now_ff;
   logic [PER_W-1:0]  per_ff;
   entry_type         entry_ff, entry_in;
   logic [TIME_W-1:0] exec_ff, exec_in;
   logic              missed_ff, missed_in;
   div_req_type       div_req_ff, div_req_in;
   div_rsp_type       div_rsp;
   entry_type         rd_data;
   logic              accept;
   logic              id_ok;
   logic              rsp_valid_ff;
   logic [ID_W-1:0]   rsp_task_ff;
   entry_type         rsp_entry_ff;
   logic [TIME_W-1:0] rsp_exec_ff;
   logic              rsp_missed_ff;

   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] exec_now;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_new;
   logic [CNT_W-1:0]  count_new;
   logic [TIME_W-1:0] act_new;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign id_ok  = (32'(req_task_id) < 32'(NUM_TASKS));

   tdm_ram u_ram (
      .clock   (clock),
      .rd_addr (TASK_AW'(req_task_id)),
      .rd_data (rd_data),
      .wr_en   ((state_ff == S_WRITE) && id_ok_ff),
      .wr_addr (TASK_AW'(id_ff)),
      .wr_data (entry_ff)
   );

   tdm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   always_comb begin
      elapsed   = now_ff - entry_ff.first_act;
      exec_now  = now_ff - entry_ff.start_time;
      sum_wide  = {1'b0, entry_ff.sum_exec} + (SUM_W+1)'(exec_now);
      sum_new   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      count_new = (entry_ff.job_count == CNT_MAX) ? CNT_MAX : entry_ff.job_count + 1'b1;
      act_new   = now_ff - div_rsp.rem;
   end

   always_comb begin
      state_in   = state_ff;
      entry_in   = entry_ff;
      exec_in    = exec_ff;
      missed_in  = missed_ff;
      div_req_in = div_req_ff;
      div_req_in.go = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            entry_in  = rd_data;
            exec_in   = '0;
            missed_in = 1'b0;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_WRITE;
            if (id_ok_ff) begin
               case (op_ff)
                  OP_INIT: begin
                     entry_in.period     = per_ff;
                     entry_in.first_act  = now_ff;
                     entry_in.last_act   = now_ff;
                     entry_in.deadline   = now_ff + TIME_W'(per_ff);
                     entry_in.start_time = '0;
                     entry_in.max_exec   = '0;
                     entry_in.sum_exec   = '0;
                     entry_in.job_count  = '0;
                     entry_in.miss       = '0;
                     entry_in.avg_exec   = '0;
                  end
                  OP_START: begin
                     entry_in.start_time = now_ff;
                     if (entry_ff.period == '0) begin
                        entry_in.last_act = entry_ff.first_act;
                        entry_in.deadline = entry_ff.first_act;
                     end else begin
                        // activation is now minus elapsed mod period
                        div_req_in.go     = 1'b1;
                        div_req_in.narrow = 1'b1;
                        div_req_in.num    = SUM_W'(elapsed);
                        div_req_in.den    = TIME_W'(entry_ff.period);
                        state_in          = S_DIVIDE;
                     end
                  end
                  OP_END: begin
                     exec_in            = exec_now;
                     entry_in.sum_exec  = sum_new;
                     entry_in.job_count = count_new;
                     if (exec_now > entry_ff.max_exec) begin
                        entry_in.max_exec = exec_now;
                     end
                     if (now_ff > entry_ff.deadline) begin
                        missed_in = 1'b1;
                        if (entry_ff.miss != CNT_MAX) begin
                           entry_in.miss = entry_ff.miss + 1'b1;
                        end
                     end
                     div_req_in.go     = 1'b1;
                     div_req_in.narrow = 1'b0;
                     div_req_in.num    = sum_new;
                     div_req_in.den    = count_new;
                     state_in          = S_DIVIDE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = S_WRITE;
               if (op_ff == OP_START) begin
                  entry_in.last_act = act_new;
                  entry_in.deadline = act_new + TIME_W'(entry_ff.period);
               end else begin
                  entry_in.avg_exec = (div_rsp.quot[SUM_W-1:TIME_W] != '0) ?
                                      TIME_MAX : div_rsp.quot[TIME_W-1:0];
               end
            end
         end
         S_WRITE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         div_req_ff.go <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= (state_ff == S_WRITE);
         div_req_ff.go <= div_req_in.go;
      end
      div_req_ff.narrow <= div_req_in.narrow;
      div_req_ff.num    <= div_req_in.num;
      div_req_ff.den    <= div_req_in.den;
      entry_ff          <= entry_in;
      exec_ff           <= exec_in;
      missed_ff         <= missed_in;
      if (accept) begin
         op_ff    <= req_op;
         id_ff    <= req_task_id;
         id_ok_ff <= id_ok;
         now_ff   <= req_now_ms;
         per_ff   <= req_period_ms;
      end
      if (state_ff == S_WRITE) begin
         rsp_task_ff   <= id_ff;
         rsp_entry_ff  <= id_ok_ff ? entry_ff : '0;
         rsp_exec_ff   <= id_ok_ff ? exec_ff : '0;
         rsp_missed_ff <= id_ok_ff && missed_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_out      = rsp_task_ff;
   assign rsp_activation_ms = rsp_entry_ff.last_act;
   assign rsp_deadline_ms   = rsp_entry_ff.deadline;
   assign rsp_exec_time_ms  = rsp_exec_ff;
   assign rsp_max_exec_ms   = rsp_entry_ff.max_exec;
   assign rsp_avg_exec_ms   = rsp_entry_ff.avg_exec;
   assign rsp_miss_count    = rsp_entry_ff.miss;
   assign rsp_missed_now    = rsp_missed_ff;

endmodule

/* sv/tdm_checker.sv */
// Port-level checks for the deadline monitor, bound to the top level.
module tdm_checker
   import tdm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [TIME_W-1:0] rsp_exec_time_ms,
   input logic [TIME_W-1:0] rsp_max_exec_ms,
   input logic [CNT_W-1:0]  rsp_miss_count,
   input logic              rsp_missed_now
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request accepted");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_missed_now |-> rsp_miss_count != '0)
      else $error("deadline miss reported but miss count is zero");

   a_max_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_exec_time_ms <= rsp_max_exec_ms)
      else $error("execution time exceeds reported maximum");

endmodule

bind periodic_task_deadline_monitor_unit tdm_checker u_tdm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_exec_time_ms (rsp_exec_time_ms),
   .rsp_max_exec_ms  (rsp_max_exec_ms),
   .rsp_miss_count   (rsp_miss_count),
   .rsp_missed_now   (rsp_missed_now)
);

/* verif/testbench.sv */
// Self-checking testbench for the periodic task deadline monitor unit.
module testbench
   import tdm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int SHOWN_MAX    = 10;

   typedef struct packed {
      logic [ID_W-1:0]   task_out;
      logic [TIME_W-1:0] activation;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] exec_time;
      logic [TIME_W-1:0] max_exec;
      logic [TIME_W-1:0] avg_exec;
      logic [CNT_W-1:0]  miss_count;
      logic              missed_now;
   } report_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [OP_W-1:0]   req_op = '0;
   logic [ID_W-1:0]   req_task_id = '0;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic [PER_W-1:0]  req_period_ms = '0;
   logic              rsp_valid;
   logic [ID_W-1:0]   rsp_task_out;
   logic [TIME_W-1:0] rsp_activation_ms;
   logic [TIME_W-1:0] rsp_deadline_ms;
   logic [TIME_W-1:0] rsp_exec_time_ms;
   logic [TIME_W-1:0] rsp_max_exec_ms;
   logic [TIME_W-1:0] rsp_avg_exec_ms;
   logic [CNT_W-1:0]  rsp_miss_count;
   logic              rsp_missed_now;

   // shadow copy of the task table
   logic [PER_W-1:0]  tab_period   [NUM_TASKS];
   logic [TIME_W-1:0] tab_first    [NUM_TASKS];
   logic [TIME_W-1:0] tab_last_act [NUM_TASKS];
   logic [TIME_W-1:0] tab_deadline [NUM_TASKS];
   logic [TIME_W-1:0] tab_started  [NUM_TASKS];
   logic [TIME_W-1:0] tab_max_exec [NUM_TASKS];
   logic [SUM_W-1:0]  tab_sum_exec [NUM_TASKS];
   logic [CNT_W-1:0]  tab_jobs     [NUM_TASKS];
   logic [CNT_W-1:0]  tab_misses   [NUM_TASKS];
   logic [TIME_W-1:0] tab_avg_exec [NUM_TASKS];

   // stimulus bookkeeping: last time stamp and period used per task
   logic [TIME_W-1:0] task_clock     [NUM_TASKS];
   logic [PER_W-1:0]  task_period_ms [NUM_TASKS];

   report_type pending_reports[$];
   int         sender_idle_pct = 25;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   periodic_task_deadline_monitor_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_task_id       (req_task_id),
      .req_now_ms        (req_now_ms),
      .req_period_ms     (req_period_ms),
      .rsp_valid         (rsp_valid),
      .rsp_task_out      (rsp_task_out),
      .rsp_activation_ms (rsp_activation_ms),
      .rsp_deadline_ms   (rsp_deadline_ms),
      .rsp_exec_time_ms  (rsp_exec_time_ms),
      .rsp_max_exec_ms   (rsp_max_exec_ms),
      .rsp_avg_exec_ms   (rsp_avg_exec_ms),
      .rsp_miss_count    (rsp_miss_count),
      .rsp_missed_now    (rsp_missed_now)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Apply one event to the shadow table and return the report it produces.
   function automatic report_type monitor_event(input logic [OP_W-1:0] op,
                                                input logic [ID_W-1:0] id,
                                                input logic [TIME_W-1:0] now,
                                                input logic [PER_W-1:0] per);
      report_type        r;
      logic [TIME_W-1:0] p32;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] quo;
      logic [TIME_W-1:0] act;
      logic [TIME_W-1:0] ex;
      logic [63:0]       total;
      logic [63:0]       mean;
      r = '0;
      r.task_out = id;
      if (int'(id) >= NUM_TASKS) return r;
      ex = '0;
      case (op)
         OP_INIT: begin
            tab_period[id]   = per;
            tab_first[id]    = now;
            tab_last_act[id] = now;
            tab_deadline[id] = now + {16'b0, per};
            tab_started[id]  = '0;
            tab_max_exec[id] = '0;
            tab_sum_exec[id] = '0;
            tab_jobs[id]     = '0;
            tab_misses[id]   = '0;
            tab_avg_exec[id] = '0;
         end
         OP_START: begin
            p32 = {16'b0, tab_period[id]};
            elapsed = now - tab_first[id];
            quo = (p32 != 0) ? elapsed / p32 : '0;
            act = tab_first[id] + quo * p32;
            tab_started[id]  = now;
            tab_last_act[id] = act;
            tab_deadline[id] = act + p32;
         end
         OP_END: begin
            ex = now - tab_started[id];
            total = {16'b0, tab_sum_exec[id]} + {32'b0, ex};
            if (total > {16'b0, SUM_MAX}) total = {16'b0, SUM_MAX};
            tab_sum_exec[id] = total[SUM_W-1:0];
            if (tab_jobs[id] != CNT_MAX) tab_jobs[id] = tab_jobs[id] + 1'b1;
            mean = total / {32'b0, tab_jobs[id]};
            if (mean > {32'b0, TIME_MAX}) mean = {32'b0, TIME_MAX};
            tab_avg_exec[id] = mean[TIME_W-1:0];
            if (ex > tab_max_exec[id]) tab_max_exec[id] = ex;
            if (now > tab_deadline[id]) begin
               r.missed_now = 1'b1;
               if (tab_misses[id] != CNT_MAX) tab_misses[id] = tab_misses[id] + 1'b1;
            end
         end
         default: ;
      endcase
      r.activation = tab_last_act[id];
      r.deadline   = tab_deadline[id];
      r.exec_time  = ex;
      r.max_exec   = tab_max_exec[id];
      r.avg_exec   = tab_avg_exec[id];
      r.miss_count = tab_misses[id];
      return r;
   endfunction

   // Drive one request, wait for it to be taken and queue its expected report.
   task automatic send_event(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] now, input logic [PER_W-1:0] per);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start         <= 1'b0;
         req_op        <= OP_W'($urandom());
         req_task_id   <= ID_W'($urandom());
         req_now_ms    <= $urandom();
         req_period_ms <= PER_W'($urandom());
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_op        <= op;
      req_task_id   <= id;
      req_now_ms    <= now;
      req_period_ms <= per;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      pending_reports.push_back(monitor_event(op, id, now, per));
      task_clock[id] = now;
      if (op == OP_INIT) task_period_ms[id] = per;
   endtask

   always @(posedge clock) begin : report_check
      report_type want;
      report_type got;
      if (!reset && rsp_valid) begin
         got = '{rsp_task_out, rsp_activation_ms, rsp_deadline_ms, rsp_exec_time_ms,
                 rsp_max_exec_ms, rsp_avg_exec_ms, rsp_miss_count, rsp_missed_now};
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MAX)
               $display("%0t: report for task %0d with no request outstanding",
                        $realtime, rsp_task_out);
         end else begin
            want = pending_reports.pop_front();
            if (got.task_out !== want.task_out || got.activation !== want.activation ||
                got.deadline !== want.deadline || got.exec_time !== want.exec_time ||
                got.max_exec !== want.max_exec || got.avg_exec !== want.avg_exec ||
                got.miss_count !== want.miss_count || got.missed_now !== want.missed_now)
            begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MAX) begin
                  $display({"%0t: mismatch exp task %0d act %h dl %h exec %h",
                            " max %h avg %h miss %h now %b"},
                           $realtime, want.task_out, want.activation, want.deadline,
                           want.exec_time, want.max_exec, want.avg_exec, want.miss_count,
                           want.missed_now);
                  $display({"%0t:          got task %0d act %h dl %h exec %h",
                            " max %h avg %h miss %h now %b"},
                           $realtime, got.task_out, got.activation, got.deadline,
                           got.exec_time, got.max_exec, got.avg_exec, got.miss_count,
                           got.missed_now);
               end
            end
         end
      end
   end

   task automatic test_table_init();
      send_event(OP_INIT, 3'd0, 32'd0, 16'd1);
      send_event(OP_INIT, 3'd7, 32'hFFFF_FFFF, 16'hFFFF);
      send_event(OP_INIT, 3'd3, 32'h8000_0000, 16'h8000);
      send_event(OP_INIT, 3'd4, 32'h5555_5555, 16'h5555);
      send_event(OP_INIT, 3'd5, 32'hAAAA_AAAA, 16'hAAAA);
      send_event(OP_INIT, 3'd6, 32'd1, 16'd2);
   endtask

   // zero period: activation stays at the first one, deadline equals it
   task automatic test_zero_period();
      send_event(OP_INIT, 3'd1, 32'd1000, 16'd0);
      send_event(OP_START, 3'd1, 32'd5000, 16'd0);
      send_event(OP_END, 3'd1, 32'd5001, 16'd0);
   endtask

   // end just before, exactly at and just after the deadline
   task automatic test_deadline_edges();
      send_event(OP_INIT, 3'd2, 32'd100, 16'd10);
      send_event(OP_START, 3'd2, 32'd125, 16'd0);
      send_event(OP_END, 3'd2, 32'd128, 16'd0);
      send_event(OP_START, 3'd2, 32'd150, 16'd0);
      send_event(OP_END, 3'd2, 32'd160, 16'd0);
      send_event(OP_START, 3'd2, 32'd165, 16'd0);
      send_event(OP_END, 3'd2, 32'd171, 16'd0);
   endtask

   // elapsed time and execution time wrap modulo 2^32; end without a start
   task automatic test_time_wrap();
      send_event(OP_START, 3'd7, 32'd10, 16'hFFFF);
      send_event(OP_END, 3'd7, 32'd9, 16'hFFFF);
      send_event(OP_END, 3'd0, 32'hFFFF_FFFF, 16'd0);
      send_event(OP_START, 3'd0, 32'd0, 16'd0);
   endtask

   task automatic test_unused_op();
      send_event(OP_UNUSED, 3'd2, 32'h1234_5678, 16'h00FF);
      send_event(OP_UNUSED, 3'd5, 32'hFFFF_FFFF, 16'hFFFF);
   endtask

   // init again clears the statistics; an end right after uses start time 0
   task automatic test_reinit();
      send_event(OP_INIT, 3'd2, 32'd200, 16'd7);
      send_event(OP_END, 3'd2, 32'd210, 16'd0);
   endtask

   task automatic test_random_jobs(input int idle_pct, input int n_items);
      int                sent;
      int                sel;
      int                p;
      logic [ID_W-1:0]   id;
      logic [PER_W-1:0]  per;
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] t1;
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < n_items) begin
         id  = ID_W'($urandom_range(0, NUM_TASKS - 1));
         p   = int'(task_period_ms[id]);
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            // well-formed job: start at or after the last time stamp, end up to 1.5 periods later
            t0 = task_clock[id] + TIME_W'($urandom_range(0, 3 * p + 2));
            if ($urandom_range(0, 15) == 0) t0 = t0 + $urandom();
            t1 = t0 + TIME_W'($urandom_range(0, p + p / 2 + 1));
            send_event(OP_START, id, t0, PER_W'($urandom()));
            send_event(OP_END, id, t1, PER_W'($urandom()));
            sent += 2;
         end else begin
            if (sel < 80) begin
               case ($urandom_range(0, 3))
                  0:       per = '0;
                  1:       per = PER_W'($urandom());
                  default: per = PER_W'($urandom_range(1, 200));
               endcase
               t0 = $urandom_range(0, 1) ? task_clock[id] : $urandom();
               send_event(OP_INIT, id, t0, per);
            end else if (sel < 87) begin
               send_event(OP_UNUSED, id, $urandom(), PER_W'($urandom()));
            end else if (sel < 94) begin
               send_event(OP_END, id, $urandom(), PER_W'($urandom()));
            end else begin
               send_event(OP_START, id, $urandom(), PER_W'($urandom()));
            end
            sent += 1;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_table_init();
      test_zero_period();
      test_deadline_edges();
      test_time_wrap();
      test_unused_op();
      test_reinit();
      test_random_jobs(25, 135);
      test_random_jobs(50, 135);
      test_random_jobs(0, 135);
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* periodic_task_deadline_monitor_unit.f */
sv/tdm_pkg.sv
sv/tdm_ram.sv
sv/tdm_div.sv
sv/periodic_task_deadline_monitor_unit.sv
sv/tdm_checker.sv
verif/testbench.sv
